/* sv/hbfn_pkg.sv */
`timescale 1ns / 1ps

package hbfn_pkg;

   // Default geometry: 65536 presence bits kept in 32-bit words.
   localparam int HBFN_UNIVERSE_BITS = 65536;
   localparam int HBFN_WORD_BITS     = 32;

   // Width of the operation code on the request channel.
   localparam int OP_BITS = 2;

   // Operation codes. Code 3 is unused and returns zero.
   typedef enum logic [OP_BITS-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_FIND  = 2'd2
   } op_type;

endpackage

/* sv/hbfn_ram.sv */
`timescale 1ns / 1ps

module hbfn_ram
   import hbfn_pkg::*;
#(
   parameter int WIDTH  = HBFN_WORD_BITS,
   parameter int DEPTH  = HBFN_UNIVERSE_BITS / HBFN_WORD_BITS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/hbfn_seq.sv */
`timescale 1ns / 1ps

module hbfn_seq
   import hbfn_pkg::*;
#(
   parameter int UNIVERSE_BITS = HBFN_UNIVERSE_BITS,
   parameter int WORD_BITS     = HBFN_WORD_BITS,
   localparam int LOG_W      = $clog2(WORD_BITS),
   localparam int LEAF_DEPTH = UNIVERSE_BITS / WORD_BITS,
   localparam int SUM_DEPTH  = (LEAF_DEPTH + WORD_BITS - 1) / WORD_BITS,
   localparam int TOP_DEPTH  = (SUM_DEPTH + WORD_BITS - 1) / WORD_BITS,
   localparam int UP_DEPTH   = SUM_DEPTH + TOP_DEPTH,
   localparam int IDX_W      = $clog2(UNIVERSE_BITS) + 1,
   localparam int LEAF_AW    = $clog2(LEAF_DEPTH),
   localparam int UP_AW      = $clog2(UP_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_BITS-1:0]   req_op,
   input  logic [IDX_W-1:0]     req_index,
   input  logic                 rsp_busy,
   output logic                 done,
   output logic [IDX_W-1:0]     result,
   output logic                 leaf_we,
   output logic [LEAF_AW-1:0]   leaf_waddr,
   output logic [WORD_BITS-1:0] leaf_wdata,
   output logic [LEAF_AW-1:0]   leaf_raddr,
   input  logic [WORD_BITS-1:0] leaf_rdata,
   output logic                 up_we,
   output logic [UP_AW-1:0]     up_waddr,
   output logic [WORD_BITS-1:0] up_wdata,
   output logic [UP_AW-1:0]     up_raddr,
   input  logic [WORD_BITS-1:0] up_rdata
);

   localparam int CAND_W = UP_AW + LOG_W + 1;
   localparam logic [WORD_BITS-1:0] MSB_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

   typedef enum logic [9:0] {
      ST_CLEAR     = 10'b0000000001,
      ST_IDLE      = 10'b0000000010,
      ST_UPD_LEAF  = 10'b0000000100,
      ST_UPD_SUM   = 10'b0000001000,
      ST_UPD_TOP   = 10'b0000010000,
      ST_FIND_LEAF = 10'b0000100000,
      ST_FIND_SUM  = 10'b0001000000,
      ST_FIND_TOP  = 10'b0010000000,
      ST_DESC_SUM  = 10'b0100000000,
      ST_DESC_LEAF = 10'b1000000000
   } state_type;

   // Count of leading zeros of a nonzero word, halving the window each step.
   function automatic logic [LOG_W-1:0] lead_zeros(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] x;
      logic [LOG_W-1:0]     n;
      x = v;
      n = '0;
      for (int k = LOG_W - 1; k >= 0; k--) begin
         if ((x >> (WORD_BITS - (1 << k))) == '0) begin
            x    = x << (1 << k);
            n[k] = 1'b1;
         end
      end
      return n;
   endfunction

   // Keep the bits at positions p and beyond, counted from the MSB.
   function automatic logic [WORD_BITS-1:0] from_pos(input logic [WORD_BITS-1:0] v,
                                                     input logic [LOG_W:0]       p);
      if (p >= (LOG_W+1)'(WORD_BITS)) begin
         return '0;
      end
      return v & (ALL_ONES >> p);
   endfunction

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 is_set_ff, is_set_in;
   logic                 first_ff, first_in;
   logic [UP_AW-1:0]     t_ff, t_in;
   logic [UP_AW-1:0]     s2_ff, s2_in;
   logic [LEAF_AW-1:0]   leaf_ff, leaf_in;
   logic [LEAF_AW-1:0]   clr_ff, clr_in;

   logic [LEAF_AW-1:0]   req_w;
   logic                 req_in_range;
   logic [LEAF_AW-1:0]   w_idx;
   logic [LOG_W-1:0]     p_pos;
   logic [LOG_W-1:0]     w_pos;
   logic [UP_AW-1:0]     s_addr;
   logic [LOG_W-1:0]     s_pos;
   logic [UP_AW-1:0]     top_addr;
   logic [UP_AW:0]       t_next;

   logic [WORD_BITS-1:0] scan_src;
   logic [LOG_W:0]       scan_from;
   logic [WORD_BITS-1:0] scan_m;
   logic                 scan_nz;
   logic [LOG_W-1:0]     lz;
   logic [UP_AW-1:0]     node;
   logic [CAND_W-1:0]    cand;
   logic [LEAF_AW-1:0]   leaf_node;
   logic [IDX_W-1:0]     leaf_hit;

   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] upd_old;
   logic [WORD_BITS-1:0] upd_new;

   assign req_w        = req_index[IDX_W-2 -: LEAF_AW];
   assign req_in_range = ~req_index[IDX_W-1];
   assign w_idx        = idx_ff[IDX_W-2 -: LEAF_AW];
   assign p_pos        = idx_ff[LOG_W-1:0];
   assign w_pos        = LOG_W'(w_idx);
   assign s_addr       = UP_AW'(w_idx >> LOG_W);
   assign s_pos        = LOG_W'(s_addr);
   assign top_addr     = UP_AW'(SUM_DEPTH) + (s_addr >> LOG_W);
   assign t_next       = {1'b0, t_ff} + (UP_AW+1)'(1);

   // One shared mask and leading-zero unit serves every level of a search.
   always_comb begin
      scan_src  = leaf_rdata;
      scan_from = '0;
      node      = s_addr;
      leaf_node = w_idx;
      case (state_ff)
         ST_FIND_LEAF: begin
            scan_from = {1'b0, p_pos};
         end
         ST_FIND_SUM: begin
            scan_src  = up_rdata;
            scan_from = {1'b0, w_pos} + (LOG_W+1)'(1);
         end
         ST_FIND_TOP: begin
            scan_src  = up_rdata;
            scan_from = first_ff ? ({1'b0, s_pos} + (LOG_W+1)'(1)) : '0;
            node      = t_ff;
         end
         ST_DESC_SUM: begin
            scan_src  = up_rdata;
            node      = s2_ff;
         end
         ST_DESC_LEAF: begin
            leaf_node = leaf_ff;
         end
         default: begin
            scan_src  = leaf_rdata;
         end
      endcase
   end

   assign scan_m   = from_pos(scan_src, scan_from);
   assign scan_nz  = |scan_m;
   assign lz       = lead_zeros(scan_m);
   assign cand     = {1'b0, node, lz};
   assign leaf_hit = {1'b0, leaf_node, lz};

   // Bit under update at the current level, and the word after the update.
   always_comb begin
      bit_mask = MSB_BIT >> p_pos;
      upd_old  = leaf_rdata;
      case (state_ff)
         ST_UPD_SUM: begin
            bit_mask = MSB_BIT >> w_pos;
            upd_old  = up_rdata;
         end
         ST_UPD_TOP: begin
            bit_mask = MSB_BIT >> s_pos;
            upd_old  = up_rdata;
         end
         default: begin
            bit_mask = MSB_BIT >> p_pos;
         end
      endcase
      upd_new = is_set_ff ? (upd_old | bit_mask) : (upd_old & ~bit_mask);
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      is_set_in  = is_set_ff;
      first_in   = first_ff;
      t_in       = t_ff;
      s2_in      = s2_ff;
      leaf_in    = leaf_ff;
      clr_in     = clr_ff;
      req_ready  = 1'b0;
      done       = 1'b0;
      result     = '0;
      leaf_we    = 1'b0;
      leaf_waddr = w_idx;
      leaf_wdata = upd_new;
      leaf_raddr = w_idx;
      up_we      = 1'b0;
      up_waddr   = s_addr;
      up_wdata   = upd_new;
      up_raddr   = s_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            leaf_we    = 1'b1;
            leaf_waddr = clr_ff;
            leaf_wdata = '0;
            up_we      = ({1'b0, clr_ff} < (LEAF_AW+1)'(UP_DEPTH));
            up_waddr   = UP_AW'(clr_ff);
            up_wdata   = '0;
            clr_in     = clr_ff + LEAF_AW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready  = ~rsp_busy;
            leaf_raddr = req_w;
            if (req_valid && !rsp_busy) begin
               idx_in    = req_index;
               is_set_in = (req_op == OP_SET);
               unique case (req_op)
                  OP_SET, OP_CLEAR: begin
                     if (req_in_range) begin
                        state_in = ST_UPD_LEAF;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_FIND: begin
                     if (req_in_range) begin
                        state_in = ST_FIND_LEAF;
                     end else begin
                        done   = 1'b1;
                        result = IDX_W'(UNIVERSE_BITS);
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         ST_UPD_LEAF: begin
            if (((upd_old & bit_mask) != '0) == is_set_ff) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               leaf_we = 1'b1;
               if (is_set_ff ? (upd_old == '0) : (upd_new == '0)) begin
                  up_raddr = s_addr;
                  state_in = ST_UPD_SUM;
               end else begin
                  done     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_UPD_SUM: begin
            up_we    = 1'b1;
            up_waddr = s_addr;
            if (is_set_ff ? (upd_old == '0) : (upd_new == '0)) begin
               up_raddr = top_addr;
               state_in = ST_UPD_TOP;
            end else begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_UPD_TOP: begin
            up_we    = 1'b1;
            up_waddr = top_addr;
            done     = 1'b1;
            state_in = ST_IDLE;
         end

         ST_FIND_LEAF: begin
            if (scan_nz) begin
               done     = 1'b1;
               result   = leaf_hit;
               state_in = ST_IDLE;
            end else begin
               up_raddr = s_addr;
               state_in = ST_FIND_SUM;
            end
         end

         ST_FIND_SUM: begin
            if (scan_nz) begin
               if (cand >= CAND_W'(LEAF_DEPTH)) begin
                  done     = 1'b1;
                  result   = IDX_W'(UNIVERSE_BITS);
                  state_in = ST_IDLE;
               end else begin
                  leaf_raddr = LEAF_AW'(cand);
                  leaf_in    = LEAF_AW'(cand);
                  state_in   = ST_DESC_LEAF;
               end
            end else begin
               up_raddr = top_addr;
               t_in     = s_addr >> LOG_W;
               first_in = 1'b1;
               state_in = ST_FIND_TOP;
            end
         end

         ST_FIND_TOP: begin
            if (scan_nz) begin
               if (cand >= CAND_W'(SUM_DEPTH)) begin
                  done     = 1'b1;
                  result   = IDX_W'(UNIVERSE_BITS);
                  state_in = ST_IDLE;
               end else begin
                  up_raddr = UP_AW'(cand);
                  s2_in    = UP_AW'(cand);
                  state_in = ST_DESC_SUM;
               end
            end else if (t_next >= (UP_AW+1)'(TOP_DEPTH)) begin
               done     = 1'b1;
               result   = IDX_W'(UNIVERSE_BITS);
               state_in = ST_IDLE;
            end else begin
               t_in     = UP_AW'(t_next);
               first_in = 1'b0;
               up_raddr = UP_AW'(SUM_DEPTH) + UP_AW'(t_next);
            end
         end

         ST_DESC_SUM: begin
            if (!scan_nz || (cand >= CAND_W'(LEAF_DEPTH))) begin
               done     = 1'b1;
               result   = IDX_W'(UNIVERSE_BITS);
               state_in = ST_IDLE;
            end else begin
               leaf_raddr = LEAF_AW'(cand);
               leaf_in    = LEAF_AW'(cand);
               state_in   = ST_DESC_LEAF;
            end
         end

         ST_DESC_LEAF: begin
            done     = 1'b1;
            result   = scan_nz ? leaf_hit : IDX_W'(UNIVERSE_BITS);
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      idx_ff    <= idx_in;
      is_set_ff <= is_set_in;
      first_ff  <= first_in;
      t_ff      <= t_in;
      s2_ff     <= s2_in;
      leaf_ff   <= leaf_in;
   end

`ifndef SYNTHESIS
   a_dual_write_only_in_clear: assert property (@(posedge clock) disable iff (reset)
      (leaf_we && up_we) |-> (state_ff == ST_CLEAR))
      else $error("leaf and upper words written together outside the clearing pass");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      done |-> (result <= IDX_W'(UNIVERSE_BITS)))
      else $error("search result beyond the universe");

   a_top_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND_TOP) |-> ({1'b0, t_ff} < (UP_AW+1)'(TOP_DEPTH)))
      else $error("top-level scan ran past the last top word");
`endif

endmodule

/* sv/hbfn_rsp.sv */
`timescale 1ns / 1ps

module hbfn_rsp
   import hbfn_pkg::*;
#(
   parameter int UNIVERSE_BITS = HBFN_UNIVERSE_BITS,
   localparam int IDX_W = $clog2(UNIVERSE_BITS) + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             done,
   input  logic [IDX_W-1:0] result,
   output logic             busy,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [IDX_W-1:0] rsp_next_index
);

   logic             out_valid_ff, out_valid_in;
   logic [IDX_W-1:0] out_data_ff, out_data_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_data_ff, pend_data_in;
   logic             out_free;

   assign out_free = ~out_valid_ff | rsp_ready;

   // A finished result goes to the output register when it is free, and to
   // the skid register otherwise.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      if (pend_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_data_in   = pend_data_ff;
            pend_valid_in = 1'b0;
         end
      end else if (done) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            pend_valid_in = 1'b1;
            pend_data_in  = result;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_data_ff  <= out_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign busy           = pend_valid_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_next_index = out_data_ff;

`ifndef SYNTHESIS
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output is empty");

   a_no_result_into_full_skid: assert property (@(posedge clock) disable iff (reset)
      !(done && pend_valid_ff))
      else $error("result finished while the skid register was full");
`endif

endmodule

/* sv/hierarchical_bitmap_find_next.sv */
`timescale 1ns / 1ps

// Channel   Direction  Ports                                  Transfer when
// request   in         req_valid, req_ready, req_op,          req_valid && req_ready
//                      req_index
// response  out        rsp_valid, rsp_ready, rsp_next_index   rsp_valid && rsp_ready
//
// One item is worked on at a time. Set and clear update the leaf word and
// then each upper word whose bit changes, each a read of the level's memory
// and a write back of a changed word. A find reads the leaf word, the summary
// word and then the top words one per cycle, stops at the first hit and
// descends through a summary read (after a top hit) and a leaf read. Codes
// without memory work finish in the cycle of the transfer.
// After reset a clearing pass zeroes every word of both memories; no request
// is taken during it.
// A stalled response is held in the output register and one more can wait in
// a skid register; a new request is taken unless the skid register is full.

module hierarchical_bitmap_find_next
   import hbfn_pkg::*;
#(
   parameter int UNIVERSE_BITS = HBFN_UNIVERSE_BITS,
   parameter int WORD_BITS     = HBFN_WORD_BITS,
   localparam int IDX_W        = $clog2(UNIVERSE_BITS) + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_BITS-1:0] req_op,
   input  logic [IDX_W-1:0]   req_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IDX_W-1:0]   rsp_next_index
);

   // Level sizes. Summary and top words share one memory: the summary words
   // come first and the top words follow them.
   localparam int LEAF_DEPTH = UNIVERSE_BITS / WORD_BITS;
   localparam int SUM_DEPTH  = (LEAF_DEPTH + WORD_BITS - 1) / WORD_BITS;
   localparam int TOP_DEPTH  = (SUM_DEPTH + WORD_BITS - 1) / WORD_BITS;
   localparam int UP_DEPTH   = SUM_DEPTH + TOP_DEPTH;
   localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
   localparam int UP_AW      = $clog2(UP_DEPTH);

   logic                 done;
   logic [IDX_W-1:0]     result;
   logic                 rsp_busy;
   logic                 leaf_we;
   logic [LEAF_AW-1:0]   leaf_waddr;
   logic [WORD_BITS-1:0] leaf_wdata;
   logic [LEAF_AW-1:0]   leaf_raddr;
   logic [WORD_BITS-1:0] leaf_rdata;
   logic                 up_we;
   logic [UP_AW-1:0]     up_waddr;
   logic [WORD_BITS-1:0] up_wdata;
   logic [UP_AW-1:0]     up_raddr;
   logic [WORD_BITS-1:0] up_rdata;

   // Leaf words: one presence bit per index.
   hbfn_ram #(
      .WIDTH  (WORD_BITS),
      .DEPTH  (LEAF_DEPTH),
      .ADDR_W (LEAF_AW)
   ) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (leaf_waddr),
      .wr_data (leaf_wdata),
      .rd_addr (leaf_raddr),
      .rd_data (leaf_rdata)
   );

   // Summary and top words: one bit per nonzero word of the level below.
   hbfn_ram #(
      .WIDTH  (WORD_BITS),
      .DEPTH  (UP_DEPTH),
      .ADDR_W (UP_AW)
   ) u_up_ram (
      .clock   (clock),
      .wr_en   (up_we),
      .wr_addr (up_waddr),
      .wr_data (up_wdata),
      .rd_addr (up_raddr),
      .rd_data (up_rdata)
   );

   // The sequencer walks the levels, updating words or searching them.
   hbfn_seq #(
      .UNIVERSE_BITS (UNIVERSE_BITS),
      .WORD_BITS     (WORD_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_index  (req_index),
      .rsp_busy   (rsp_busy),
      .done       (done),
      .result     (result),
      .leaf_we    (leaf_we),
      .leaf_waddr (leaf_waddr),
      .leaf_wdata (leaf_wdata),
      .leaf_raddr (leaf_raddr),
      .leaf_rdata (leaf_rdata),
      .up_we      (up_we),
      .up_waddr   (up_waddr),
      .up_wdata   (up_wdata),
      .up_raddr   (up_raddr),
      .up_rdata   (up_rdata)
   );

   // Output register with a one-entry skid behind it.
   hbfn_rsp #(
      .UNIVERSE_BITS (UNIVERSE_BITS)
   ) u_rsp (
      .clock          (clock),
      .reset          (reset),
      .done           (done),
      .result         (result),
      .busy           (rsp_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_index (rsp_next_index)
   );

endmodule
